// ----- rtl/tps_pkg.sv -----
// triangle path step: shared constants, edge codes and the lane flag struct
// no dependencies; used by tps_div and triangle_path_step_top
package tps_pkg;

   localparam int FRAC_BITS = 16;
   localparam int TOL_BITS  = 8;

   localparam logic [TOL_BITS-1:0] TOL_RESET = 8'd1;

   localparam logic [1:0] EDGE_NONE = 2'd0;
   localparam logic [1:0] EDGE_AB   = 2'd1;
   localparam logic [1:0] EDGE_BC   = 2'd2;
   localparam logic [1:0] EDGE_CA   = 2'd3;

   localparam logic [1:0] EDGE_CODE [3] = '{EDGE_AB, EDGE_BC, EDGE_CA};

   // per-edge control that rides along with the divider data
   typedef struct packed {
      logic acc;     // crossing accepted
      logic zero_t;  // negative time, treated as zero; the tolerance is applied through acc
      logic sat;     // quotient would overflow, time saturates
   } tps_lane_type;

endpackage

// ----- rtl/triangle_path_step_top.sv -----
// triangle path step top: edge normals, crossing times, earliest exit, advance
// depends on tps_pkg and tps_div
// one item per cycle while the output buffer is not full; nine arithmetic stages, one divider
//   stage per quotient bit, three selection/advance stages, then a two-entry output buffer
// the whole pipeline holds only while the output buffer is full
// reset clears stage valid bits and the output buffer and sets time_tolerance to 1
module triangle_path_step_top #(
   parameter int COORD_BITS = 20,
   parameter int TIME_BITS  = 24
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    csr_valid,
   output logic                    csr_ready,
   input  logic [7:0]              csr_time_tolerance,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  logic [3*COORD_BITS-1:0] req_vertex_a,
   input  logic [3*COORD_BITS-1:0] req_vertex_b,
   input  logic [3*COORD_BITS-1:0] req_vertex_c,
   input  logic [3*COORD_BITS-1:0] req_start_position,
   input  logic [3*COORD_BITS-1:0] req_velocity,
   input  logic                    req_reverse,
   input  logic [TIME_BITS-1:0]    req_time_budget,
   input  logic [15:0]             req_triangle_id,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output logic [3*COORD_BITS-1:0] rsp_new_position,
   output logic [TIME_BITS-1:0]    rsp_time_left,
   output logic [1:0]              rsp_exit_edge,
   output logic [TIME_BITS-1:0]    rsp_exit_time,
   output logic                    rsp_no_exit,
   output logic [15:0]             rsp_triangle_out
);
   import tps_pkg::*;

   localparam int CB  = COORD_BITS;
   localparam int TB  = TIME_BITS;
   localparam int DW  = CB + 1;
   localparam int MW  = 2 * DW;
   localparam int PW  = MW + 2;
   localparam int H   = PW / 2;
   localparam int HW  = PW - H;
   localparam int BW  = 2 * PW;
   localparam int ND  = BW + 1;
   localparam int NUMW = ND + FRAC_BITS;
   localparam int SW  = ND + TB + FRAC_BITS;
   localparam int PRW = DW + TB + 2;
   localparam int RW2 = PRW - FRAC_BITS + 1;
   localparam int DIV_IDX = 9;
   localparam int T_IDX   = DIV_IDX + TB;
   localparam int SEL_IDX = T_IDX + 1;
   localparam int NS      = SEL_IDX + 2;
   localparam int NSD     = SEL_IDX + 1;

   typedef struct packed {
      logic [3*CB-1:0] pos;
      logic [3*DW-1:0] vel;
      logic [TB-1:0]   budget;
      logic [15:0]     id;
   } side_type;

   typedef struct packed {
      logic [3*CB-1:0] pos;
      logic [TB-1:0]   time_left;
      logic [1:0]      edge_code;
      logic [TB-1:0]   exit_time;
      logic            no_exit;
      logic [15:0]     id;
   } rsp_type;

   logic en;
   logic [TOL_BITS-1:0] tol_ff;
   logic vld_ff [NS];
   side_type side_in;
   side_type side_ff [NSD];

   // ---------------- configuration
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid) begin
         tol_ff <= csr_time_tolerance;
      end
   end

   // ---------------- stage 1: unpack and edge vectors
   logic signed [DW-1:0] ca_c [3], cb_c [3], cc_c [3], cp_c [3], cv_c [3];
   logic signed [DW-1:0] e1_ff [3], e2_ff [3], vel1_ff [3];
   logic signed [DW-1:0] u_ff [3][3], w_ff [3][3];

   always_comb begin
      side_in.pos    = req_start_position;
      side_in.budget = req_time_budget;
      side_in.id     = req_triangle_id;
      side_in.vel    = '0;
      for (int j = 0; j < 3; j++) begin
         ca_c[j] = DW'($signed(req_vertex_a[j*CB +: CB]));
         cb_c[j] = DW'($signed(req_vertex_b[j*CB +: CB]));
         cc_c[j] = DW'($signed(req_vertex_c[j*CB +: CB]));
         cp_c[j] = DW'($signed(req_start_position[j*CB +: CB]));
         cv_c[j] = req_reverse ? -DW'($signed(req_velocity[j*CB +: CB]))
                               :  DW'($signed(req_velocity[j*CB +: CB]));
         side_in.vel[j*DW +: DW] = cv_c[j];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            e1_ff[j]   <= cb_c[j] - ca_c[j];
            e2_ff[j]   <= cc_c[j] - ca_c[j];
            vel1_ff[j] <= cv_c[j];
            u_ff[0][j] <= ca_c[j] - cb_c[j];
            u_ff[1][j] <= cb_c[j] - cc_c[j];
            u_ff[2][j] <= cc_c[j] - ca_c[j];
            w_ff[0][j] <= ca_c[j] - cp_c[j];
            w_ff[1][j] <= cb_c[j] - cp_c[j];
            w_ff[2][j] <= cc_c[j] - cp_c[j];
         end
      end
   end

   // ---------------- stage 2: element products
   logic signed [MW-1:0] pue2_ff [3][3], pue1_ff [3][3];
   logic signed [MW-1:0] pe1w_ff [3][3], pe2w_ff [3][3];
   logic signed [MW-1:0] pe1v_ff [3], pe2v_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            pe1v_ff[j] <= MW'(e1_ff[j]) * MW'(vel1_ff[j]);
            pe2v_ff[j] <= MW'(e2_ff[j]) * MW'(vel1_ff[j]);
            for (int k = 0; k < 3; k++) begin
               pue2_ff[k][j] <= MW'(u_ff[k][j]) * MW'(e2_ff[j]);
               pue1_ff[k][j] <= MW'(u_ff[k][j]) * MW'(e1_ff[j]);
               pe1w_ff[k][j] <= MW'(e1_ff[j]) * MW'(w_ff[k][j]);
               pe2w_ff[k][j] <= MW'(e2_ff[j]) * MW'(w_ff[k][j]);
            end
         end
      end
   end

   // ---------------- stage 3: dot product sums
   logic signed [PW-1:0] due2_ff [3], due1_ff [3], de1w_ff [3], de2w_ff [3];
   logic signed [PW-1:0] de1v_ff, de2v_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         de1v_ff <= PW'(pe1v_ff[0]) + PW'(pe1v_ff[1]) + PW'(pe1v_ff[2]);
         de2v_ff <= PW'(pe2v_ff[0]) + PW'(pe2v_ff[1]) + PW'(pe2v_ff[2]);
         for (int k = 0; k < 3; k++) begin
            due2_ff[k] <= PW'(pue2_ff[k][0]) + PW'(pue2_ff[k][1]) + PW'(pue2_ff[k][2]);
            due1_ff[k] <= PW'(pue1_ff[k][0]) + PW'(pue1_ff[k][1]) + PW'(pue1_ff[k][2]);
            de1w_ff[k] <= PW'(pe1w_ff[k][0]) + PW'(pe1w_ff[k][1]) + PW'(pe1w_ff[k][2]);
            de2w_ff[k] <= PW'(pe2w_ff[k][0]) + PW'(pe2w_ff[k][1]) + PW'(pe2w_ff[k][2]);
         end
      end
   end

   // ---------------- stage 4: partial products of the wide multiplies
   // operand pairs: den = ue2*e1v - ue1*e2v, num = ue2*e1w - ue1*e2w
   logic [PW-1:0] opa_c [3][4], opb_c [3][4];
   logic signed [2*HW-1:0] pp_hh_ff [3][4];
   logic signed [HW+H:0]   pp_hl_ff [3][4], pp_lh_ff [3][4];
   logic [2*H-1:0]         pp_ll_ff [3][4];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         opa_c[k][0] = due2_ff[k];  opb_c[k][0] = de1v_ff;
         opa_c[k][1] = due1_ff[k];  opb_c[k][1] = de2v_ff;
         opa_c[k][2] = due2_ff[k];  opb_c[k][2] = de1w_ff[k];
         opa_c[k][3] = due1_ff[k];  opb_c[k][3] = de2w_ff[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 4; m++) begin
               pp_hh_ff[k][m] <= (2*HW)'($signed(opa_c[k][m][PW-1:H]))
                               * (2*HW)'($signed(opb_c[k][m][PW-1:H]));
               pp_hl_ff[k][m] <= (HW+H+1)'($signed(opa_c[k][m][PW-1:H]))
                               * (HW+H+1)'($signed({1'b0, opb_c[k][m][H-1:0]}));
               pp_lh_ff[k][m] <= (HW+H+1)'($signed({1'b0, opa_c[k][m][H-1:0]}))
                               * (HW+H+1)'($signed(opb_c[k][m][PW-1:H]));
               pp_ll_ff[k][m] <= (2*H)'(opa_c[k][m][H-1:0]) * (2*H)'(opb_c[k][m][H-1:0]);
            end
         end
      end
   end

   // ---------------- stage 5: combine partial products
   logic [BW-1:0] prod_ff [3][4];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            for (int m = 0; m < 4; m++) begin
               prod_ff[k][m] <= (BW'(pp_hh_ff[k][m]) << (2*H))
                              + ((BW'(pp_hl_ff[k][m]) + BW'(pp_lh_ff[k][m])) << H)
                              + BW'(pp_ll_ff[k][m]);
            end
         end
      end
   end

   // ---------------- stage 6: normal dot products
   logic signed [ND-1:0] den_ff [3], num_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            den_ff[k] <= ND'($signed(prod_ff[k][0])) - ND'($signed(prod_ff[k][1]));
            num_ff[k] <= ND'($signed(prod_ff[k][2])) - ND'($signed(prod_ff[k][3]));
         end
      end
   end

   // ---------------- stage 7: signs and magnitudes
   logic dneg7_ff [3], npos7_ff [3];
   logic [ND-1:0] dmag7_ff [3], nmag7_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dneg7_ff[k] <= den_ff[k][ND-1];
            npos7_ff[k] <= !num_ff[k][ND-1] && (num_ff[k] != '0);
            dmag7_ff[k] <= den_ff[k][ND-1] ? ND'(-den_ff[k]) : ND'(den_ff[k]);
            nmag7_ff[k] <= num_ff[k][ND-1] ? ND'(-num_ff[k]) : ND'(num_ff[k]);
         end
      end
   end

   // ---------------- stage 8: tolerance limit
   logic dneg8_ff [3], npos8_ff [3];
   logic [ND-1:0] dmag8_ff [3], nmag8_ff [3];
   logic [ND+TOL_BITS-1:0] lim_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            dneg8_ff[k] <= dneg7_ff[k];
            npos8_ff[k] <= npos7_ff[k];
            dmag8_ff[k] <= dmag7_ff[k];
            nmag8_ff[k] <= nmag7_ff[k];
            lim_ff[k]   <= (ND+TOL_BITS)'(dmag7_ff[k]) * (ND+TOL_BITS)'(tol_ff);
         end
      end
   end

   // ---------------- stage 9: acceptance and saturation checks
   logic [NUMW-1:0] r0_c [3];
   logic [NUMW-1:0] r0_ff [3];
   logic [ND-1:0]   dmag9_ff [3];
   tps_lane_type    fl9_ff [3];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         r0_c[k] = {nmag8_ff[k], {FRAC_BITS{1'b0}}};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            r0_ff[k]    <= r0_c[k];
            dmag9_ff[k] <= dmag8_ff[k];
            fl9_ff[k].zero_t <= npos8_ff[k];
            fl9_ff[k].acc    <= dneg8_ff[k]
                                && (!npos8_ff[k] || (NUMW'(lim_ff[k]) >= r0_c[k]));
            fl9_ff[k].sat    <= SW'(r0_c[k]) >= SW'({dmag8_ff[k], {TB{1'b0}}});
         end
      end
   end

   // ---------------- divider lanes
   logic [TB-1:0] q_c [3];
   tps_lane_type  fld_c [3];

   for (genvar k = 0; k < 3; k++) begin : g_lane
      tps_div #(
         .NDW (ND),
         .QW  (TB)
      ) u_div (
         .clock     (clock),
         .en        (en),
         .num_in    (r0_ff[k]),
         .den_in    (dmag9_ff[k]),
         .flags_in  (fl9_ff[k]),
         .q_out     (q_c[k]),
         .flags_out (fld_c[k])
      );
   end

   // ---------------- crossing times
   logic [TB-1:0] t_ff [3];
   logic          tacc_ff [3];

   always_ff @(posedge clock) begin
      if (en) begin
         for (int k = 0; k < 3; k++) begin
            tacc_ff[k] <= fld_c[k].acc;
            if (fld_c[k].zero_t) begin
               t_ff[k] <= '0;
            end else if (fld_c[k].sat) begin
               t_ff[k] <= '1;
            end else begin
               t_ff[k] <= q_c[k];
            end
         end
      end
   end

   // ---------------- earliest crossing, ties to the lower edge
   logic [TB-1:0] best_c, best_ff;
   logic [1:0]    sel_c, sel_ff;

   always_comb begin
      best_c = '0;
      sel_c  = EDGE_NONE;
      for (int k = 0; k < 3; k++) begin
         if (tacc_ff[k] && (sel_c == EDGE_NONE || t_ff[k] < best_c)) begin
            best_c = t_ff[k];
            sel_c  = EDGE_CODE[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         best_ff <= best_c;
         sel_ff  <= sel_c;
      end
   end

   // ---------------- decision and displacement products
   side_type sd;
   logic stay_c;
   logic [TB-1:0] tuse_c;
   logic signed [PRW-1:0] vt_ff [3];
   logic [3*CB-1:0] dpos_ff;
   logic [TB-1:0]   dleft_ff, dtime_ff;
   logic [1:0]      dedge_ff;
   logic            dnoex_ff;
   logic [15:0]     did_ff;

   assign sd     = side_ff[SEL_IDX];
   assign stay_c = (sel_ff == EDGE_NONE) || (sd.budget <= best_ff);
   assign tuse_c = stay_c ? sd.budget : best_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         for (int j = 0; j < 3; j++) begin
            vt_ff[j] <= PRW'($signed(sd.vel[j*DW +: DW])) * PRW'($signed({1'b0, tuse_c}));
         end
         dpos_ff  <= sd.pos;
         dleft_ff <= stay_c ? '0 : sd.budget - best_ff;
         dedge_ff <= stay_c ? EDGE_NONE : sel_ff;
         dtime_ff <= (sel_ff == EDGE_NONE) ? '1 : best_ff;
         dnoex_ff <= (sel_ff == EDGE_NONE);
         did_ff   <= sd.id;
      end
   end

   // ---------------- position update with rounding and saturation
   logic signed [PRW-1:0] rnd_c [3];
   logic signed [PRW-1:0] shr_c [3];
   logic signed [RW2-1:0] sum_c [3];
   rsp_type push_c;

   always_comb begin
      push_c.time_left = dleft_ff;
      push_c.edge_code = dedge_ff;
      push_c.exit_time = dtime_ff;
      push_c.no_exit   = dnoex_ff;
      push_c.id        = did_ff;
      push_c.pos       = '0;
      for (int j = 0; j < 3; j++) begin
         rnd_c[j] = vt_ff[j] + $signed(PRW'(1) << (FRAC_BITS - 1));
         shr_c[j] = rnd_c[j] >>> FRAC_BITS;
         sum_c[j] = RW2'(shr_c[j]) + RW2'($signed(dpos_ff[j*CB +: CB]));
         // in range when all bits above the coordinate's sign bit agree
         if (sum_c[j][RW2-1:CB-1] == '0 || sum_c[j][RW2-1:CB-1] == '1) begin
            push_c.pos[j*CB +: CB] = sum_c[j][CB-1:0];
         end else if (sum_c[j][RW2-1]) begin
            push_c.pos[j*CB +: CB] = {1'b1, {(CB-1){1'b0}}};
         end else begin
            push_c.pos[j*CB +: CB] = {1'b0, {(CB-1){1'b1}}};
         end
      end
   end

   // ---------------- valid bits and side payload
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NS; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (en) begin
         vld_ff[0] <= req_valid;
         for (int i = 1; i < NS; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < NSD; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   // ---------------- two-entry output buffer
   logic [1:0] fcnt_ff;
   rsp_type    head_ff, tail_ff;
   logic       push, pop;

   assign en        = (fcnt_ff != 2'd2);
   assign req_ready = en;
   assign push      = en && vld_ff[NS-1];
   assign pop       = rsp_valid && rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         fcnt_ff <= 2'd0;
      end else begin
         case ({push, pop})
            2'b10:   fcnt_ff <= fcnt_ff + 2'd1;
            2'b01:   fcnt_ff <= fcnt_ff - 2'd1;
            default: fcnt_ff <= fcnt_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (push && (fcnt_ff == 2'd0 || pop)) begin
         head_ff <= push_c;
      end else if (pop) begin
         head_ff <= tail_ff;
      end
      if (push && !pop && fcnt_ff == 2'd1) begin
         tail_ff <= push_c;
      end
   end

   assign rsp_valid        = (fcnt_ff != 2'd0);
   assign rsp_new_position = head_ff.pos;
   assign rsp_time_left    = head_ff.time_left;
   assign rsp_exit_edge    = head_ff.edge_code;
   assign rsp_exit_time    = head_ff.exit_time;
   assign rsp_no_exit      = head_ff.no_exit;
   assign rsp_triangle_out = head_ff.id;

   // ---------------- assertions
   a_fcnt_range: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff != 2'd3)
      else $error("output buffer count out of range");

   a_no_exit_stays: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_no_exit |-> rsp_exit_edge == EDGE_NONE && rsp_time_left == '0
                                   && rsp_exit_time == '1)
      else $error("no-exit result carries an edge or leftover time");

   a_exit_has_left: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_exit_edge != EDGE_NONE |-> rsp_time_left != '0 && !rsp_no_exit)
      else $error("edge exit without leftover time");

   a_full_stalls: assert property (@(posedge clock) disable iff (reset)
      fcnt_ff == 2'd2 && !pop |=> fcnt_ff == 2'd2)
      else $error("full output buffer changed without a transfer");

endmodule

// ----- rtl/tps_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on tps_pkg (FRAC_BITS, tps_lane_type)
module tps_div #(
   parameter int NDW = 89,
   parameter int QW  = 24
) (
   input  logic                               clock,
   input  logic                               en,
   input  logic [NDW+tps_pkg::FRAC_BITS-1:0]  num_in,
   input  logic [NDW-1:0]                     den_in,
   input  tps_pkg::tps_lane_type              flags_in,
   output logic [QW-1:0]                      q_out,
   output tps_pkg::tps_lane_type              flags_out
);
   import tps_pkg::*;

   localparam int RW = NDW + FRAC_BITS + QW;

   logic [RW-1:0]  rem_ff [QW];
   logic [NDW-1:0] den_ff [QW];
   logic [QW-1:0]  q_ff   [QW];
   tps_lane_type   fl_ff  [QW];

   for (genvar s = 0; s < QW; s++) begin : g_stg
      logic [RW-1:0]  r_cur;
      logic [RW-1:0]  d_sh;
      logic [NDW-1:0] d_cur;
      logic [QW-1:0]  q_cur;
      tps_lane_type   f_cur;

      if (s == 0) begin : g_first
         assign r_cur = RW'(num_in);
         assign d_cur = den_in;
         assign q_cur = '0;
         assign f_cur = flags_in;
      end else begin : g_next
         assign r_cur = rem_ff[s-1];
         assign d_cur = den_ff[s-1];
         assign q_cur = q_ff[s-1];
         assign f_cur = fl_ff[s-1];
      end

      assign d_sh = RW'(d_cur) << (QW - 1 - s);

      always_ff @(posedge clock) begin
         if (en) begin
            if (r_cur >= d_sh) begin
               rem_ff[s] <= r_cur - d_sh;
               q_ff[s]   <= q_cur | (QW'(1) << (QW - 1 - s));
            end else begin
               rem_ff[s] <= r_cur;
               q_ff[s]   <= q_cur;
            end
            den_ff[s] <= d_cur;
            fl_ff[s]  <= f_cur;
         end
      end
   end

   assign q_out     = q_ff[QW-1];
   assign flags_out = fl_ff[QW-1];

endmodule

// ----- dv/tb_top.sv -----
// testbench for triangle_path_step_top: a bit-exact predictor with a queue of expected exits
// depends on tps_pkg and triangle_path_step_top; self-checking, no external files
`timescale 1ns / 1ps

module tb_top;
   import tps_pkg::*;

   localparam int CB = 20;
   localparam int TB = 24;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 50;

   typedef logic signed [127:0] wide_type;

   typedef struct {
      logic [3*CB-1:0] vertex_a, vertex_b, vertex_c, start_position, velocity;
      logic            reverse;
      logic [TB-1:0]   time_budget;
      logic [15:0]     triangle_id;
   } particle_req_type;

   typedef struct {
      logic [3*CB-1:0] new_position;
      logic [TB-1:0]   time_left;
      logic [1:0]      exit_edge;
      logic [TB-1:0]   exit_time;
      logic            no_exit;
      logic [15:0]     triangle_out;
   } particle_rsp_type;

   logic            clock = 0;
   logic            reset = 1;
   logic            csr_valid = 0;
   logic            csr_ready;
   logic [7:0]      csr_time_tolerance = '0;
   logic            req_valid = 0;
   logic            req_ready;
   logic [3*CB-1:0] req_vertex_a = '0, req_vertex_b = '0, req_vertex_c = '0;
   logic [3*CB-1:0] req_start_position = '0, req_velocity = '0;
   logic            req_reverse = 0;
   logic [TB-1:0]   req_time_budget = '0;
   logic [15:0]     req_triangle_id = '0;
   logic            rsp_valid;
   logic            rsp_ready = 0;
   logic [3*CB-1:0] rsp_new_position;
   logic [TB-1:0]   rsp_time_left;
   logic [1:0]      rsp_exit_edge;
   logic [TB-1:0]   rsp_exit_time;
   logic            rsp_no_exit;
   logic [15:0]     rsp_triangle_out;

   particle_rsp_type expected_exits[$];
   logic [7:0]    tolerance_model = TOL_RESET;
   int            mismatches = 0;
   int            req_idle_pct = 0;
   int            rsp_idle_pct = 0;
   int            hold_requests = 0;
   int            idle_cycles = 0;

   triangle_path_step_top #(.COORD_BITS(CB), .TIME_BITS(TB)) u_dut (.*);

   always #10 clock = ~clock;

   function automatic longint coord(logic [3*CB-1:0] packed_xyz, int k);
      return longint'($signed(packed_xyz[k*CB +: CB]));
   endfunction

   function automatic logic [3*CB-1:0] pack_xyz(longint x, longint y, longint z);
      logic [CB-1:0] px, py, pz;
      px = x[CB-1:0];
      py = y[CB-1:0];
      pz = z[CB-1:0];
      return {pz, py, px};
   endfunction

   function automatic longint dot3(longint x[3], longint y[3]);
      return x[0]*y[0] + x[1]*y[1] + x[2]*y[2];
   endfunction

   // (u x n) . w with n = e1 x e2, expanded so it stays exact
   function automatic wide_type edge_normal_dot(longint u[3], longint e1[3], longint e2[3],
                                                longint w[3]);
      return wide_type'(dot3(u, e2)) * wide_type'(dot3(e1, w))
           - wide_type'(dot3(u, e1)) * wide_type'(dot3(e2, w));
   endfunction

   function automatic logic [3*CB-1:0] advance_position(longint p[3], longint v[3],
                                                        logic [TB-1:0] t);
      longint hi, lo, r[3];
      hi = (longint'(1) << (CB-1)) - 1;
      lo = -hi - 1;
      for (int k = 0; k < 3; k++) begin
         r[k] = p[k] + ((v[k] * longint'(t) + 32768) >>> 16);
         if (r[k] > hi) r[k] = hi;
         if (r[k] < lo) r[k] = lo;
      end
      return pack_xyz(r[0], r[1], r[2]);
   endfunction

   function automatic particle_rsp_type predict_exit(particle_req_type r, logic [7:0] tol);
      particle_rsp_type o;
      longint a[3], b[3], c[3], p[3], v[3], e1[3], e2[3], u[3][3], w[3][3];
      logic [TB-1:0] tmax, best, t;
      logic [1:0] sel;
      wide_type den, num;
      logic [127:0] dmag, nmag;
      tmax = '1;
      best = '0;
      sel = EDGE_NONE;
      for (int k = 0; k < 3; k++) begin
         a[k] = coord(r.vertex_a, k);
         b[k] = coord(r.vertex_b, k);
         c[k] = coord(r.vertex_c, k);
         p[k] = coord(r.start_position, k);
         v[k] = coord(r.velocity, k);
         if (r.reverse) v[k] = -v[k];
         e1[k] = b[k] - a[k];
         e2[k] = c[k] - a[k];
         u[0][k] = a[k] - b[k]; w[0][k] = a[k] - p[k];
         u[1][k] = b[k] - c[k]; w[1][k] = b[k] - p[k];
         u[2][k] = c[k] - a[k]; w[2][k] = c[k] - p[k];
      end
      for (int k = 0; k < 3; k++) begin
         den = edge_normal_dot(u[k], e1, e2, v);
         if (den < 0) begin
            num = edge_normal_dot(u[k], e1, e2, w[k]);
            dmag = -den;
            nmag = (num < 0) ? -num : num;
            if (num > 0) begin
               // crossing lies behind: accepted as zero only within tolerance
               if ({120'd0, tol} * dmag < (nmag << 16)) continue;
               t = '0;
            end else if ((nmag << 16) >= (dmag << TB)) begin
               t = tmax;
            end else begin
               t = TB'((nmag << 16) / dmag);
            end
            if (sel == EDGE_NONE || t < best) begin
               best = t;
               sel = EDGE_CODE[k];
            end
         end
      end
      o.no_exit = (sel == EDGE_NONE);
      o.exit_time = o.no_exit ? tmax : best;
      o.triangle_out = r.triangle_id;
      if (o.no_exit || r.time_budget <= best) begin
         o.new_position = advance_position(p, v, r.time_budget);
         o.time_left = '0;
         o.exit_edge = EDGE_NONE;
      end else begin
         o.new_position = advance_position(p, v, best);
         o.time_left = r.time_budget - best;
         o.exit_edge = sel;
      end
      return o;
   endfunction

   // ---------------- drivers ----------------

   task automatic send_particle(particle_req_type r);
      while ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 0;
         @(posedge clock);
      end
      req_valid          <= 1;
      req_vertex_a       <= r.vertex_a;
      req_vertex_b       <= r.vertex_b;
      req_vertex_c       <= r.vertex_c;
      req_start_position <= r.start_position;
      req_velocity       <= r.velocity;
      req_reverse        <= r.reverse;
      req_time_budget    <= r.time_budget;
      req_triangle_id    <= r.triangle_id;
      do @(negedge clock); while (!req_ready);
      expected_exits.insert(expected_exits.size(), predict_exit(r, tolerance_model));
      @(posedge clock);
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_exits.size() != 0) @(posedge clock);
   endtask

   task automatic write_tolerance(logic [7:0] value);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_valid <= 1;
      csr_time_tolerance <= value;
      do @(negedge clock); while (!csr_ready);
      tolerance_model = value;
      @(posedge clock);
      csr_valid <= 0;
   endtask

   function automatic longint rand_signed(int bits);
      longint m;
      m = longint'($urandom_range((1 << bits) - 1));
      return m - (longint'(1) << (bits - 1));
   endfunction

   function automatic particle_req_type random_particle();
      particle_req_type r;
      longint a[3], b[3], c[3], p[3];
      int scale, vscale;
      r.reverse = 1'($urandom_range(1));
      r.triangle_id = 16'($urandom);
      if ($urandom_range(99) < 15) begin
         // raw noise covering every bit
         r.vertex_a = (3*CB)'({$urandom, $urandom});
         r.vertex_b = (3*CB)'({$urandom, $urandom});
         r.vertex_c = (3*CB)'({$urandom, $urandom});
         r.start_position = (3*CB)'({$urandom, $urandom});
         r.velocity = (3*CB)'({$urandom, $urandom});
         r.time_budget = TB'($urandom);
         return r;
      end
      scale = $urandom_range(6, 18);
      vscale = $urandom_range(4, 20);
      for (int k = 0; k < 3; k++) begin
         a[k] = rand_signed(scale);
         b[k] = rand_signed(scale);
         c[k] = rand_signed(scale);
         // per coordinate: half the time the centroid's, otherwise on or just past vertex a's
         case ($urandom_range(3))
            0:       p[k] = a[k];
            1:       p[k] = a[k] + rand_signed(2);
            default: p[k] = (a[k] + b[k] + c[k]) / 3;
         endcase
      end
      r.vertex_a = pack_xyz(a[0], a[1], a[2]);
      r.vertex_b = pack_xyz(b[0], b[1], b[2]);
      r.vertex_c = pack_xyz(c[0], c[1], c[2]);
      r.start_position = pack_xyz(p[0], p[1], p[2]);
      r.velocity = pack_xyz(rand_signed(vscale), rand_signed(vscale), rand_signed(vscale));
      case ($urandom_range(3))
         0:       r.time_budget = TB'($urandom_range(255));
         1:       r.time_budget = TB'($urandom_range(1 << 18));
         2:       r.time_budget = {TB{1'b1}};
         default: r.time_budget = TB'($urandom);
      endcase
      return r;
   endfunction

   // ---------------- receiver, checker, watchdog ----------------

   always @(posedge clock) begin : rsp_stall
      int hold_seen, hold_left;
      if (reset) begin
         rsp_ready <= 0;
      end else if (hold_seen != hold_requests) begin
         hold_seen = hold_requests;
         hold_left = 300;
         rsp_ready <= 0;
      end else if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rsp_idle_pct);
      end
   end

   always @(negedge clock) begin
      particle_rsp_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_exits.size() == 0) begin
            $error("result transfer with nothing expected");
            mismatches++;
         end else begin
            e = expected_exits.pop_front();
            if (rsp_new_position !== e.new_position) begin
               $error("new_position exp %h got %h", e.new_position, rsp_new_position);
               mismatches++;
            end
            if (rsp_time_left !== e.time_left) begin
               $error("time_left exp %h got %h", e.time_left, rsp_time_left);
               mismatches++;
            end
            if (rsp_exit_edge !== e.exit_edge) begin
               $error("exit_edge exp %0d got %0d", e.exit_edge, rsp_exit_edge);
               mismatches++;
            end
            if (rsp_exit_time !== e.exit_time) begin
               $error("exit_time exp %h got %h", e.exit_time, rsp_exit_time);
               mismatches++;
            end
            if (rsp_no_exit !== e.no_exit) begin
               $error("no_exit exp %0d got %0d", e.no_exit, rsp_no_exit);
               mismatches++;
            end
            if (rsp_triangle_out !== e.triangle_out) begin
               $error("triangle_out exp %h got %h", e.triangle_out, rsp_triangle_out);
               mismatches++;
            end
         end
      end
   end

   always @(negedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready))
         idle_cycles = 0;
      else
         idle_cycles++;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   // ---------------- tests ----------------

   task automatic send_unit_triangle(longint px, longint py, longint vx, longint vy,
                                     logic [TB-1:0] budget);
      particle_req_type r;
      r.vertex_a = pack_xyz(0, 0, 0);
      r.vertex_b = pack_xyz(4096, 0, 0);
      r.vertex_c = pack_xyz(0, 4096, 0);
      r.start_position = pack_xyz(px, py, 0);
      r.velocity = pack_xyz(vx, vy, 0);
      r.reverse = 1'b0;
      r.time_budget = budget;
      r.triangle_id = 16'($urandom);
      send_particle(r);
   endtask

   task automatic test_directed();
      particle_req_type r;
      send_unit_triangle(1000, 1000, 32768, 0, TB'(1 << 16));      // exits through bc
      send_unit_triangle(1000, 1000, 0, -32768, TB'(1 << 20));     // exits through ab
      send_unit_triangle(1000, 1000, -32768, 0, TB'(1 << 20));     // exits through ca
      send_unit_triangle(1000, 1000, 32768, 32768, TB'(16));       // budget fits
      send_unit_triangle(1000, 1000, 0, 0, TB'(1000));             // zero velocity
      send_unit_triangle(0, 0, -32768, -32768, TB'(1000));         // corner, tie ab then ca
      send_unit_triangle(1000, -1, 0, -32768, TB'(1000));          // behind ab by two time lsbs
      send_unit_triangle(1000, -1, 0, -262144, TB'(1000));         // behind ab, fraction of a lsb
      send_unit_triangle(1000, -200, 0, -1, TB'(1000));            // far behind ab
      send_unit_triangle(1000, 1000, 1, 0, {TB{1'b1}});            // crossing time saturates
      send_unit_triangle(1000, 1000, -524288, -524288, TB'(0));    // zero budget, extreme velocity
      send_unit_triangle(524287, 524287, 524287, 524287, {TB{1'b1}}); // position saturates
      r.vertex_a = '0; r.vertex_b = '0; r.vertex_c = '0;      // degenerate triangle
      r.start_position = '0; r.velocity = pack_xyz(100, 0, 0);
      r.reverse = 1'b1; r.time_budget = TB'(1 << 16); r.triangle_id = 16'hffff;
      send_particle(r);
      r.vertex_a = '1; r.vertex_b = '1; r.vertex_c = '1;
      r.start_position = '1; r.velocity = '1; r.time_budget = '1; r.triangle_id = '0;
      send_particle(r);
      r.vertex_b = pack_xyz(-524288, 0, 0); r.vertex_c = pack_xyz(0, 524287, 0);
      r.vertex_a = pack_xyz(524287, -524288, 0); r.start_position = '0;
      r.velocity = pack_xyz(-524288, 524287, -524288); r.reverse = 1'b1;
      send_particle(r);
   endtask

   task automatic test_random(int count);
      repeat (count) send_particle(random_particle());
   endtask

   task automatic test_backpressure();
      hold_requests++;
      test_random(80);
      wait_drained();
      test_random(20);
   endtask

   initial begin
      repeat (5) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      write_tolerance(8'd0);
      test_directed();
      write_tolerance(8'd255);
      test_directed();
      req_idle_pct = 36; rsp_idle_pct = 74;
      test_random(300);
      write_tolerance(8'($urandom));
      req_idle_pct = 74; rsp_idle_pct = 36;
      test_random(250);
      write_tolerance(8'd1);
      req_idle_pct = 0; rsp_idle_pct = 0;
      test_random(355);
      test_backpressure();
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/tps_pkg.sv
rtl/tps_div.sv
rtl/triangle_path_step_top.sv
dv/tb_top.sv
